// ===== rtl/khdr_pkg.sv =====
// Shared types, constants and hash functions of the key hash destination router.
package khdr_pkg;

  typedef enum logic [1:0] {
    MODE_RR   = 2'd0,
    MODE_DJB2 = 2'd1,
    MODE_XOR  = 2'd2,
    MODE_OAAT = 2'd3
  } placement_mode_t;

  localparam logic [31:0] SEED_DJB2 = 32'd5381;
  localparam logic [31:0] SEED_XOR  = 32'h5555_5555;
  localparam logic [31:0] SEED_ZERO = 32'h0000_0000;
  localparam logic [4:0]  CORE_MAX  = 5'd31;

  typedef struct packed {
    logic            cmd;
    placement_mode_t mode;
    logic [31:0]     hash;
  } hash_item_t;

  typedef struct packed {
    logic [7:0]  dest_x;
    logic [7:0]  dest_y;
    logic [4:0]  dest_core;
    logic        routed;
    logic [31:0] key_hash;
  } dest_t;

  function automatic logic [31:0] seed_of(placement_mode_t mode);
    case (mode)
      MODE_DJB2: return SEED_DJB2;
      MODE_XOR:  return SEED_XOR;
      default:   return SEED_ZERO;
    endcase
  endfunction

  function automatic logic [31:0] absorb(placement_mode_t mode, logic [31:0] h,
                                         logic [7:0] b);
    logic [31:0] t;
    t = h;
    case (mode)
      MODE_DJB2: t = (h << 5) + h + {24'd0, b};
      MODE_XOR:  t = (h ^ {24'd0, b}) << 5;
      MODE_OAAT: begin
        t = h + {24'd0, b};
        t = t + (t << 10);
        t = t ^ (t >> 6);
      end
      default:   t = h;
    endcase
    return t;
  endfunction

  function automatic logic [31:0] finish(placement_mode_t mode, logic [31:0] h);
    logic [31:0] t;
    t = h;
    if (mode == MODE_OAAT) begin
      t = t + (t << 3);
      t = t ^ (t >> 11);
      t = t + (t << 15);
    end
    return t;
  endfunction

  // Remainder of a byte by a constant divisor d of 1 to 256, with m = 65536 / d + 1.
  function automatic logic [7:0] rem8(logic [7:0] v, logic [8:0] d, logic [16:0] m);
    logic [24:0] p;
    logic [7:0]  q;
    logic [16:0] qd;
    logic [16:0] r;
    p  = {17'd0, v} * {8'd0, m};
    q  = p[23:16];
    qd = {9'd0, q} * {8'd0, d};
    r  = {9'd0, v} - qd;
    return r[7:0];
  endfunction

endpackage

// ===== rtl/khdr_req_if.sv =====
// Request channel: one key byte per transaction.
interface khdr_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] key_byte;
  logic       last_byte;

  modport source (output valid, cmd, key_byte, last_byte, input ready);
  modport sink   (input valid, cmd, key_byte, last_byte, output ready);
endinterface

// ===== rtl/khdr_dest_if.sv =====
// Destination channel: one routing result per transaction.
interface khdr_dest_if;
  logic        valid;
  logic        ready;
  logic [7:0]  dest_x;
  logic [7:0]  dest_y;
  logic [4:0]  dest_core;
  logic        routed;
  logic [31:0] key_hash;

  modport source (output valid, dest_x, dest_y, dest_core, routed, key_hash, input ready);
  modport sink   (input valid, dest_x, dest_y, dest_core, routed, key_hash, output ready);
endinterface

// ===== rtl/khdr_hash.sv =====
// Running hash accumulator and the stage that holds a finished key.
module khdr_hash (
  input  logic                     clk,
  input  logic                     rst,
  input  khdr_pkg::placement_mode_t mode,
  input  logic                     mode_load,
  input  khdr_pkg::placement_mode_t new_mode,
  input  logic                     accept,
  input  logic                     cmd,
  input  logic [7:0]               key_byte,
  input  logic                     last_byte,
  input  logic                     item_take,
  output logic                     item_valid,
  output khdr_pkg::hash_item_t     item
);
  import khdr_pkg::*;

  logic [31:0] acc;
  logic [31:0] acc_next;

  assign acc_next = absorb(mode, acc, key_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= seed_of(MODE_DJB2);
    end else if (mode_load) begin
      acc <= seed_of(new_mode);
    end else if (accept) begin
      acc <= last_byte ? seed_of(mode) : acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept && last_byte) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      item.cmd  <= cmd;
      item.mode <= mode;
      item.hash <= acc_next;
    end
  end

endmodule

// ===== rtl/khdr_place.sv =====
// Placement: hash split into column, row and core, round-robin counters, result register.
module khdr_place #(
  parameter int GRID_COLS       = 2,
  parameter int GRID_ROWS       = 2,
  parameter int LEAF_COUNT      = 16,
  parameter int FIRST_LEAF_CORE = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  khdr_pkg::hash_item_t item,
  output logic                 item_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output khdr_pkg::dest_t      out
);
  import khdr_pkg::*;

  localparam int         COL_D     = (GRID_COLS < 1) ? 1 : GRID_COLS;
  localparam int         ROW_D     = (GRID_ROWS < 1) ? 1 : GRID_ROWS;
  localparam int         LEAF_D    = (LEAF_COUNT < 1) ? 1 : LEAF_COUNT;
  localparam logic [8:0] COL_DIV   = 9'(COL_D);
  localparam logic [8:0] ROW_DIV   = 9'(ROW_D);
  localparam logic [8:0] LEAF_DIV  = 9'(LEAF_D);
  localparam logic [16:0] COL_RCP  = 17'(65536 / COL_D + 1);
  localparam logic [16:0] ROW_RCP  = 17'(65536 / ROW_D + 1);
  localparam logic [16:0] LEAF_RCP = 17'(65536 / LEAF_D + 1);
  localparam logic [8:0] FIRST_W   = 9'(FIRST_LEAF_CORE);
  localparam logic [4:0] FIRST_C   = 5'(FIRST_LEAF_CORE);
  localparam logic [4:0] RR_CORE0  = 5'(FIRST_LEAF_CORE - 1);
  localparam logic [5:0] LEAF_TOP  = 6'((FIRST_LEAF_CORE + LEAF_COUNT - 1 > 31) ?
                                        31 : FIRST_LEAF_CORE + LEAF_COUNT - 1);

  logic [7:0]  rr_column;
  logic [7:0]  rr_row;
  logic [4:0]  rr_core;
  logic [7:0]  rr_column_next;
  logic [7:0]  rr_row_next;
  logic [4:0]  rr_core_next;
  logic [5:0]  core_inc;
  logic [8:0]  col_inc;
  logic [8:0]  row_inc;
  logic        core_wrap;
  logic        col_wrap;
  logic        row_wrap;
  logic [31:0] h;
  logic [7:0]  leaf_rem;
  logic [8:0]  core_sum;
  logic        rr_put;
  dest_t       result;

  assign item_take = item_valid && (!out_valid || out_ready);
  assign rr_put    = (item.mode == MODE_RR) && !item.cmd;

  always_comb begin
    core_inc  = {1'b0, rr_core} + 6'd1;
    col_inc   = {1'b0, rr_column} + 9'd1;
    row_inc   = {1'b0, rr_row} + 9'd1;
    core_wrap = core_inc > LEAF_TOP;
    col_wrap  = col_inc >= COL_DIV;
    row_wrap  = row_inc >= ROW_DIV;
    rr_core_next   = core_wrap ? FIRST_C : core_inc[4:0];
    rr_column_next = rr_column;
    rr_row_next    = rr_row;
    if (core_wrap) begin
      rr_column_next = col_wrap ? 8'd0 : col_inc[7:0];
      if (col_wrap) begin
        rr_row_next = row_wrap ? 8'd0 : row_inc[7:0];
      end
    end
  end

  always_comb begin
    h        = finish(item.mode, item.hash);
    leaf_rem = rem8(h[7:0], LEAF_DIV, LEAF_RCP);
    core_sum = {1'b0, leaf_rem} + FIRST_W;
    result   = '0;
    if (item.mode != MODE_RR) begin
      result.dest_x    = rem8(h[23:16], COL_DIV, COL_RCP);
      result.dest_y    = rem8(h[15:8], ROW_DIV, ROW_RCP);
      result.dest_core = (core_sum > {4'd0, CORE_MAX}) ? CORE_MAX : core_sum[4:0];
      result.routed    = 1'b1;
      result.key_hash  = h;
    end else if (!item.cmd) begin
      result.dest_x    = rr_column_next;
      result.dest_y    = rr_row_next;
      result.dest_core = rr_core_next;
      result.routed    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rr_column <= 8'd0;
      rr_row    <= 8'd0;
      rr_core   <= RR_CORE0;
    end else if (item_take && rr_put) begin
      rr_column <= rr_column_next;
      rr_row    <= rr_row_next;
      rr_core   <= rr_core_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out <= result;
    end
  end

endmodule

// ===== rtl/key_hash_destination_router.sv =====
// Key hash destination router: top level.
// Takes one key byte per cycle on req and keeps a running 32-bit hash (djb2, xor-shift-5 or
// one-at-a-time, set by placement_mode; mode 0 places puts round robin and answers pulls as
// unrouted). Only a byte marked last_byte yields a result on dest, after it passes the hash stage
// register and then the result register. A new byte is taken every cycle, and req stalls only
// when both the hash stage and the result register hold items that dest has not taken.
// Write placement_mode only while no key is in flight; a write drops any partly hashed key.
module key_hash_destination_router #(
  parameter int GRID_COLS       = 2,
  parameter int GRID_ROWS       = 2,
  parameter int LEAF_COUNT      = 16,
  parameter int FIRST_LEAF_CORE = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_data,
  khdr_req_if.sink          req,
  khdr_dest_if.source       dest
);
  import khdr_pkg::*;

  localparam logic [4:0] CORE_LO = 5'(FIRST_LEAF_CORE);
  localparam logic [5:0] CORE_HI = 6'((FIRST_LEAF_CORE + LEAF_COUNT - 1 > 31) ?
                                      31 : FIRST_LEAF_CORE + LEAF_COUNT - 1);

  placement_mode_t mode;
  logic            accept;
  logic            item_valid;
  logic            item_take;
  hash_item_t      item;
  dest_t           result;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DJB2;
    end else if (cfg_we) begin
      mode <= placement_mode_t'(cfg_data);
    end
  end

  assign req.ready = !item_valid || item_take;
  assign accept    = req.valid && req.ready;

  khdr_hash u_hash (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .mode_load  (cfg_we),
    .new_mode   (placement_mode_t'(cfg_data)),
    .accept     (accept),
    .cmd        (req.cmd),
    .key_byte   (req.key_byte),
    .last_byte  (req.last_byte),
    .item_take  (item_take),
    .item_valid (item_valid),
    .item       (item)
  );

  khdr_place #(
    .GRID_COLS       (GRID_COLS),
    .GRID_ROWS       (GRID_ROWS),
    .LEAF_COUNT      (LEAF_COUNT),
    .FIRST_LEAF_CORE (FIRST_LEAF_CORE)
  ) u_place (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_valid  (dest.valid),
    .out_ready  (dest.ready),
    .out        (result)
  );

  assign dest.dest_x    = result.dest_x;
  assign dest.dest_y    = result.dest_y;
  assign dest.dest_core = result.dest_core;
  assign dest.routed    = result.routed;
  assign dest.key_hash  = result.key_hash;

  a_unrouted_zero: assert property (@(posedge clk) disable iff (rst)
    dest.valid && !dest.routed |->
      dest.dest_x == 8'd0 && dest.dest_y == 8'd0 && dest.dest_core == 5'd0 &&
      dest.key_hash == 32'd0)
    else $error("unrouted transaction carries a destination");

  a_unrouted_rr: assert property (@(posedge clk) disable iff (rst)
    dest.valid && !dest.routed |-> mode == MODE_RR)
    else $error("unrouted transaction outside round-robin mode");

  a_core_range: assert property (@(posedge clk) disable iff (rst)
    dest.valid && dest.routed |->
      dest.dest_core >= CORE_LO && {1'b0, dest.dest_core} <= CORE_HI)
    else $error("routed core outside leaf range");

endmodule
